@@ rtl/core/agc_pkg.sv @@
`timescale 1ns / 1ps
// agc_pkg: shared types and constants for the gain control core
// used by agc_ctrl, agc_dp, the top level and the checker; no dependencies

package agc_pkg;

    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 24;
    localparam int LEVEL_W  = 15;
    localparam int RATE_W   = 16;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 24;

    localparam logic [GAIN_W-1:0]  UNITY_GAIN       = 24'h010000;
    localparam logic [LEVEL_W-1:0] TARGET_DEFAULT   = 15'd16384;
    localparam logic [LEVEL_W-1:0] TARGET_RESET     = 15'd16384;
    localparam logic [GAIN_W-1:0]  MAX_GAIN_RESET   = 24'd262144;
    localparam logic [RATE_W-1:0]  ATTACK_RESET     = 16'd655;
    localparam logic [RATE_W-1:0]  DECAY_RESET      = 16'd66;
    localparam logic [LEVEL_W-1:0] GATE_RESET       = 15'd655;

    typedef enum logic [ADDR_W-1:0] {
        REG_TARGET_LEVEL = 3'd0,
        REG_MAX_GAIN     = 3'd1,
        REG_ATTACK_RATE  = 3'd2,
        REG_DECAY_RATE   = 3'd3,
        REG_GATE_LEVEL   = 3'd4
    } cfg_idx_t;

    // datapath commands; load_x may come with update
    typedef struct packed {
        logic load_x;
        logic mul_gain;
        logic limit;
        logic mul_rate;
        logic update;
    } dp_cmd_t;

endpackage

@@ rtl/core/agc_ctrl.sv @@
`timescale 1ns / 1ps
// agc_ctrl: sequencing state machine for the gain control core
// depends on agc_pkg; drives the datapath through agc_pkg::dp_cmd_t

module agc_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    output agc_pkg::dp_cmd_t cmd
);

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_MUL_GAIN = 5'b00010,
        S_LIMIT    = 5'b00100,
        S_MUL_RATE = 5'b01000,
        S_UPDATE   = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;
    logic   finish;
    logic   accept;

    assign out_free = !m_valid_reg || m_ready;
    assign finish   = (state_reg == S_UPDATE) && out_free;
    assign s_ready  = (state_reg == S_IDLE) || finish;
    assign accept   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_MUL_GAIN;
                end
            end
            S_MUL_GAIN: state_next = S_LIMIT;
            S_LIMIT:    state_next = S_MUL_RATE;
            S_MUL_RATE: state_next = S_UPDATE;
            S_UPDATE: begin
                if (finish) begin
                    state_next = accept ? S_MUL_GAIN : S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (finish) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_comb begin
        cmd          = '0;
        cmd.load_x   = accept;
        cmd.mul_gain = (state_reg == S_MUL_GAIN);
        cmd.limit    = (state_reg == S_LIMIT);
        cmd.mul_rate = (state_reg == S_MUL_RATE);
        cmd.update   = finish;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

@@ rtl/core/agc_dp.sv @@
`timescale 1ns / 1ps
// agc_dp: gain control datapath with one shared multiplier, limiter and gain clamp
// depends on agc_pkg; sequenced by agc_ctrl

module agc_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  agc_pkg::dp_cmd_t                    cmd,
    input  logic                                cfg_wr_en,
    input  logic [agc_pkg::ADDR_W-1:0]          cfg_addr,
    input  logic [agc_pkg::DATA_W-1:0]          cfg_wdata,
    input  logic signed [agc_pkg::SAMPLE_W-1:0] s_sample_in,
    output logic signed [agc_pkg::SAMPLE_W-1:0] m_sample_out,
    output logic [agc_pkg::GAIN_W-1:0]          m_gain_used
);

    logic [agc_pkg::LEVEL_W-1:0] target_reg;
    logic [agc_pkg::GAIN_W-1:0]  max_gain_reg;
    logic [agc_pkg::RATE_W-1:0]  attack_reg;
    logic [agc_pkg::RATE_W-1:0]  decay_reg;
    logic [agc_pkg::LEVEL_W-1:0] gate_reg;
    logic [agc_pkg::GAIN_W-1:0]  gain_reg, gain_next;

    logic signed [15:0] x_reg;
    logic signed [41:0] prod_reg;
    logic signed [15:0] y_reg, y_next;
    logic signed [16:0] err_reg, err_next;
    logic               open_reg, open_next;
    logic signed [15:0] out_sample_reg;
    logic [23:0]        out_gain_reg;

    logic signed [16:0] mul_a;
    logic signed [24:0] mul_b;
    logic signed [41:0] mul_p;
    logic [15:0]        rate_sel;

    logic signed [41:0] lim_sum;
    logic signed [25:0] lim_r;
    logic [15:0]        y_abs;
    logic [15:0]        x_abs;
    logic [14:0]        tgt_eff;

    logic signed [41:0] upd_sum;
    logic signed [17:0] delta;
    logic signed [25:0] g_sum;
    logic [23:0]        gmax_eff;

    // shared multiplier: sample by gain, then error by rate
    assign rate_sel = err_reg[16] ? attack_reg : decay_reg;
    assign mul_a    = cmd.mul_gain ? 17'(x_reg) : err_reg;
    assign mul_b    = cmd.mul_gain ? $signed({1'b0, gain_reg})
                                   : $signed({9'b0, rate_sel});
    assign mul_p    = mul_a * mul_b;

    // round to Q1.15 and saturate
    assign tgt_eff = (target_reg == '0) ? agc_pkg::TARGET_DEFAULT : target_reg;
    assign lim_sum = prod_reg + 42'sd32768;
    assign lim_r   = lim_sum[41:16];

    always_comb begin
        if (lim_r > 26'sd32767) begin
            y_next = 16'sd32767;
        end else if (lim_r < -26'sd32768) begin
            y_next = -16'sd32768;
        end else begin
            y_next = lim_r[15:0];
        end
        y_abs     = y_next[15] ? 16'(~y_next + 16'sd1) : 16'(y_next);
        x_abs     = x_reg[15] ? 16'(~x_reg + 16'sd1) : 16'(x_reg);
        open_next = x_abs > {1'b0, gate_reg};
        err_next  = $signed({2'b00, tgt_eff}) - $signed({1'b0, y_abs});
    end

    // round delta to Q8.16, add it while the gate is open, then clamp
    assign gmax_eff = (max_gain_reg < agc_pkg::UNITY_GAIN) ? agc_pkg::UNITY_GAIN
                                                           : max_gain_reg;
    assign upd_sum  = prod_reg + 42'sd16384;
    assign delta    = upd_sum[32:15];

    always_comb begin
        g_sum = $signed({2'b00, gain_reg});
        if (open_reg) begin
            g_sum = g_sum + 26'(delta);
        end
        if (g_sum < $signed({2'b00, agc_pkg::UNITY_GAIN})) begin
            gain_next = agc_pkg::UNITY_GAIN;
        end else if (g_sum > $signed({2'b00, gmax_eff})) begin
            gain_next = gmax_eff;
        end else begin
            gain_next = g_sum[23:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg   <= agc_pkg::TARGET_RESET;
            max_gain_reg <= agc_pkg::MAX_GAIN_RESET;
            attack_reg   <= agc_pkg::ATTACK_RESET;
            decay_reg    <= agc_pkg::DECAY_RESET;
            gate_reg     <= agc_pkg::GATE_RESET;
            gain_reg     <= agc_pkg::UNITY_GAIN;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    agc_pkg::REG_TARGET_LEVEL: target_reg   <= cfg_wdata[14:0];
                    agc_pkg::REG_MAX_GAIN:     max_gain_reg <= cfg_wdata[23:0];
                    agc_pkg::REG_ATTACK_RATE:  attack_reg   <= cfg_wdata[15:0];
                    agc_pkg::REG_DECAY_RATE:   decay_reg    <= cfg_wdata[15:0];
                    agc_pkg::REG_GATE_LEVEL:   gate_reg     <= cfg_wdata[14:0];
                    default: ;
                endcase
            end
            if (cmd.update) begin
                gain_reg <= gain_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_x) begin
            x_reg <= s_sample_in;
        end
        if (cmd.mul_gain || cmd.mul_rate) begin
            prod_reg <= mul_p;
        end
        if (cmd.limit) begin
            y_reg    <= y_next;
            err_reg  <= err_next;
            open_reg <= open_next;
        end
        if (cmd.update) begin
            out_sample_reg <= y_reg;
            out_gain_reg   <= gain_reg;
        end
    end

    assign m_sample_out = out_sample_reg;
    assign m_gain_used  = out_gain_reg;

endmodule

@@ rtl/core/agc_attack_decay_limiter_core.sv @@
`timescale 1ns / 1ps
// agc_attack_decay_limiter_core: per-sample automatic gain control with limiter
// depends on agc_pkg, agc_ctrl and agc_dp
//
// Usage:
//   s_valid/s_ready carry one Q1.15 sample per request on s_sample_in.
//   m_valid/m_ready return the limited sample (m_sample_out) and the Q8.16
//   gain that was applied to it (m_gain_used), one result per request.
//   cfg_wr_en/cfg_addr/cfg_wdata write the five settings (target level,
//   maximum gain, attack rate, decay rate, gate level); the user writes them
//   only while idle (the block does not enforce it); unknown addresses are ignored.
//   Each accepted sample passes the gain multiply, limit, rate multiply and
//   update steps; a new one is taken only as the last finishes, since the
//   single shared multiplier forms the gained sample and then the gain step.
//   Reset (aresetn low, synchronous) loads the default settings, sets the gain
//   to unity and empties the output register.
//   Stall: a finished result waits in the output register; the next request is
//   accepted and worked on meanwhile, and the block holds in its last step
//   until the output register frees.

module agc_attack_decay_limiter_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [agc_pkg::SAMPLE_W-1:0] s_sample_in,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [agc_pkg::SAMPLE_W-1:0] m_sample_out,
    output logic [agc_pkg::GAIN_W-1:0]          m_gain_used,
    input  logic                                cfg_wr_en,
    input  logic [agc_pkg::ADDR_W-1:0]          cfg_addr,
    input  logic [agc_pkg::DATA_W-1:0]          cfg_wdata
);

    agc_pkg::dp_cmd_t cmd;

    agc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    agc_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .s_sample_in  (s_sample_in),
        .m_sample_out (m_sample_out),
        .m_gain_used  (m_gain_used)
    );

endmodule

@@ rtl/core/agc_chk.sv @@
`timescale 1ns / 1ps
// agc_chk: port-level checker for the gain control core, bound to the top level
// depends on agc_pkg and agc_attack_decay_limiter_core

module agc_chk (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic signed [agc_pkg::SAMPLE_W-1:0] m_sample_out,
    input logic [agc_pkg::GAIN_W-1:0]          m_gain_used
);

    // no result survives a reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sample_out) && $stable(m_gain_used))
        else $error("stalled result changed");

    // applied gain never below unity
    a_gain_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_gain_used >= agc_pkg::UNITY_GAIN)
        else $error("gain below unity");

    // one request in flight: no acceptance in the cycle after one
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted back to back");

endmodule

bind agc_attack_decay_limiter_core agc_chk u_agc_chk (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_sample_out (m_sample_out),
    .m_gain_used  (m_gain_used)
);
